### rtl/gdcu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdcu_pkg
// Shared codes, widths and constants for the gamepad drive command unit.
// ----------------------------------------------------------------------------
package gdcu_pkg;

  // word kinds carried in in_tuser
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POLL   = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_TMO    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HAND_GAIN_L   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HAND_GAIN_R   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJ_GAIN_L    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJ_GAIN_R    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HAND_SPIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJ_SPIN      = 3'd7;

  // field widths
  localparam int STICK_W  = 8;
  localparam int BTN_W    = 14;
  localparam int GAIN_W   = 20;
  localparam int TMO_W    = 16;
  localparam int SPEED_W  = 22;
  localparam int TURN_W   = 21;
  localparam int INDEX_W  = 8;
  localparam int SILENCE_W = 32;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 80;

  // behaviour constants
  localparam int DEAD_ZONE       = 38;
  localparam int LINK_TIMEOUT_MS = 5000;
  localparam int MAX_INDEX       = 255;
  localparam int INDEX_LIMIT     = (MAX_INDEX > 255) ? 255 : MAX_INDEX;

  // register reset values
  localparam logic              RST_AUTO_ENABLE = 1'b1;
  localparam logic [TMO_W-1:0]  RST_MOTION_TMO  = 16'd500;
  localparam logic [GAIN_W-1:0] RST_HAND_GAIN_L = 20'd384000;
  localparam logic [GAIN_W-1:0] RST_HAND_GAIN_R = 20'd25600;
  localparam logic [GAIN_W-1:0] RST_ADJ_GAIN_L  = 20'd25600;
  localparam logic [GAIN_W-1:0] RST_ADJ_GAIN_R  = 20'd7680;
  localparam logic [GAIN_W-1:0] RST_HAND_SPIN   = 20'd128;
  localparam logic [GAIN_W-1:0] RST_ADJ_SPIN    = 20'd128;

endpackage

### rtl/gamepad_drive_command_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_drive_command_unit
// Button edge logic, mode/lock/index state and Q.7 drive speed computation.
// ----------------------------------------------------------------------------
// Path: an accepted word is held in the input register and is then registered
// into the output register, where out_tvalid rises with it.
// Throughput: one word per cycle; the input register and the output register
// each take a new word whenever the stage behind them moves.
// Reset: synchronous, active low; all state, counters and configuration
// registers return to their defaults and both stages are emptied.
module gamepad_drive_command_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] left_stick_x, [15:8] left_stick_y, [23:16] right_stick_x,
  // [31:24] right_stick_y, [45:32] button_bits, [47:46] zero
  input  logic [gdcu_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] kind
  input  logic [gdcu_pkg::KIND_W-1:0]        in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [21:0] speed_x, [43:22] speed_y, [64:44] speed_turn, [65] auto_active,
  // [66] locked, [74:67] step_index, [75] motion_timed_out,
  // [76] link_timed_out, [77] container_request, [78] lift_request, [79] zero
  output logic [gdcu_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_we,
  input  logic [gdcu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gdcu_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SW = gdcu_pkg::SPEED_W;
  localparam int TW = gdcu_pkg::TURN_W;
  localparam int GW = gdcu_pkg::GAIN_W;
  localparam int IW = gdcu_pkg::INDEX_W;
  localparam int LW = gdcu_pkg::SILENCE_W;

  // configuration
  logic          auto_enable_r;
  logic [gdcu_pkg::TMO_W-1:0] motion_tmo_r;
  logic [GW-1:0] hand_gain_l_r, hand_gain_r_r, adj_gain_l_r, adj_gain_r_r;
  logic [GW-1:0] hand_spin_r, adj_spin_r;

  // input stage
  logic                            s1_valid_r;
  logic [gdcu_pkg::KIND_W-1:0]     s1_kind_r;
  logic [gdcu_pkg::IN_TDATA_W-1:0] s1_data_r;

  // block state
  logic          mode_auto_r, mode_auto_nxt;
  logic          lock_r, lock_nxt;
  logic [IW-1:0] index_r, index_nxt;
  logic [4:0]    prior_btn_r, prior_btn_nxt;
  logic signed [7:0] lx_r, ly_r, rx_r, ry_r;
  logic signed [7:0] lx_nxt, ly_nxt, rx_nxt, ry_nxt;
  logic [1:0]    spin_btn_r, spin_btn_nxt;
  logic [1:0]    arm_req_r, arm_req_nxt;
  logic          connected_r, connected_nxt;
  logic [LW-1:0] silence_r, silence_nxt;
  logic signed [SW-1:0] speed_x_r, speed_x_nxt, speed_y_r, speed_y_nxt;
  logic signed [TW-1:0] turn_r, turn_nxt;

  // output stage
  logic                             out_valid_r;
  logic [gdcu_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic       fire;
  logic [13:0] btn;
  logic [4:0]  btn_now, rise;
  logic [1:0]  req;
  logic        motion_tmo, link_tmo;
  logic [GW-1:0] gain_l, gain_r, spin;

  function automatic logic signed [7:0] dead_zone(input logic signed [7:0] v);
    if (v >= -gdcu_pkg::DEAD_ZONE && v <= gdcu_pkg::DEAD_ZONE) begin
      return 8'sd0;
    end
    return v;
  endfunction

  // -(a*ga + b*gb) with floor division by 128
  function automatic logic signed [SW-1:0] scaled_sum(
    input logic signed [7:0] a,
    input logic signed [7:0] b,
    input logic [GW-1:0]     ga,
    input logic [GW-1:0]     gb
  );
    logic signed [31:0] pa, pb, s;
    pa = 32'(dead_zone(a)) * signed'(32'(ga));
    pb = 32'(dead_zone(b)) * signed'(32'(gb));
    s  = -(pa + pb);
    return s[SW+6:7];
  endfunction

  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;

  assign btn     = s1_data_r[45:32];
  // bit4 triangle, bit3 circle, bit2 cross, bit1 left, bit0 right
  assign btn_now = {btn[7], btn[5], btn[4], btn[3], btn[2]};
  assign rise    = btn_now & ~prior_btn_r;

  assign gain_l = mode_auto_r ? adj_gain_l_r : hand_gain_l_r;
  assign gain_r = mode_auto_r ? adj_gain_r_r : hand_gain_r_r;
  assign spin   = mode_auto_r ? adj_spin_r   : hand_spin_r;

  always_comb begin
    mode_auto_nxt = mode_auto_r;
    lock_nxt      = lock_r;
    index_nxt     = index_r;
    prior_btn_nxt = prior_btn_r;
    lx_nxt        = lx_r;
    ly_nxt        = ly_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    spin_btn_nxt  = spin_btn_r;
    arm_req_nxt   = arm_req_r;
    connected_nxt = connected_r;
    silence_nxt   = silence_r;
    speed_x_nxt   = speed_x_r;
    speed_y_nxt   = speed_y_r;
    turn_nxt      = turn_r;
    req           = 2'b00;
    case (s1_kind_r)
      gdcu_pkg::KIND_REPORT: begin
        lx_nxt       = s1_data_r[7:0];
        ly_nxt       = s1_data_r[15:8];
        rx_nxt       = s1_data_r[23:16];
        ry_nxt       = s1_data_r[31:24];
        spin_btn_nxt = {btn[11], btn[10]};
        if (rise[3] && auto_enable_r) begin
          if (!mode_auto_r) begin
            mode_auto_nxt = 1'b1;
            lock_nxt      = 1'b0;
          end else begin
            lock_nxt = 1'b1;
          end
        end
        // decrement first, then increment, both against the updated lock
        if (rise[1] && !lock_nxt && index_r != '0) begin
          index_nxt = index_r - 1'b1;
        end
        if (rise[0] && !lock_nxt && index_nxt < IW'(gdcu_pkg::INDEX_LIMIT)) begin
          index_nxt = index_nxt + 1'b1;
        end
        arm_req_nxt   = arm_req_r | {rise[4], rise[2]};
        prior_btn_nxt = btn_now;
        connected_nxt = 1'b1;
        silence_nxt   = '0;
      end
      gdcu_pkg::KIND_TICK: begin
        silence_nxt = silence_r + 1'b1;
      end
      gdcu_pkg::KIND_POLL: begin
        req         = arm_req_r;
        arm_req_nxt = 2'b00;
        if (connected_r && silence_r > LW'(motion_tmo_r)) begin
          speed_x_nxt = '0;
          speed_y_nxt = '0;
          turn_nxt    = '0;
        end else if (!(mode_auto_r && lock_r)) begin
          speed_y_nxt = scaled_sum(lx_r, rx_r, gain_l, gain_r);
          speed_x_nxt = scaled_sum(ly_r, ry_r, gain_l, gain_r);
          case (spin_btn_r)
            2'b01:   turn_nxt = signed'({1'b0, spin});
            2'b10:   turn_nxt = -signed'({1'b0, spin});
            default: turn_nxt = '0;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign motion_tmo = connected_nxt && silence_nxt > LW'(motion_tmo_r);
  assign link_tmo   = connected_nxt && silence_nxt > LW'(gdcu_pkg::LINK_TIMEOUT_MS);

  assign out_data_nxt = {1'b0, req[1], req[0], link_tmo, motion_tmo, index_nxt,
                         lock_nxt, mode_auto_nxt, turn_nxt, speed_y_nxt, speed_x_nxt};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_enable_r <= gdcu_pkg::RST_AUTO_ENABLE;
      motion_tmo_r  <= gdcu_pkg::RST_MOTION_TMO;
      hand_gain_l_r <= gdcu_pkg::RST_HAND_GAIN_L;
      hand_gain_r_r <= gdcu_pkg::RST_HAND_GAIN_R;
      adj_gain_l_r  <= gdcu_pkg::RST_ADJ_GAIN_L;
      adj_gain_r_r  <= gdcu_pkg::RST_ADJ_GAIN_R;
      hand_spin_r   <= gdcu_pkg::RST_HAND_SPIN;
      adj_spin_r    <= gdcu_pkg::RST_ADJ_SPIN;
    end else if (cfg_we) begin
      case (cfg_index)
        gdcu_pkg::CFG_AUTO_ENABLE: auto_enable_r <= cfg_data[0];
        gdcu_pkg::CFG_MOTION_TMO:  motion_tmo_r  <= cfg_data[gdcu_pkg::TMO_W-1:0];
        gdcu_pkg::CFG_HAND_GAIN_L: hand_gain_l_r <= cfg_data;
        gdcu_pkg::CFG_HAND_GAIN_R: hand_gain_r_r <= cfg_data;
        gdcu_pkg::CFG_ADJ_GAIN_L:  adj_gain_l_r  <= cfg_data;
        gdcu_pkg::CFG_ADJ_GAIN_R:  adj_gain_r_r  <= cfg_data;
        gdcu_pkg::CFG_HAND_SPIN:   hand_spin_r   <= cfg_data;
        gdcu_pkg::CFG_ADJ_SPIN:    adj_spin_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r <= in_tuser;
      s1_data_r <= in_tdata;
    end
  end

  // block state, advanced once per word leaving the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_auto_r <= 1'b0;
      lock_r      <= 1'b0;
      index_r     <= '0;
      prior_btn_r <= '0;
      lx_r        <= '0;
      ly_r        <= '0;
      rx_r        <= '0;
      ry_r        <= '0;
      spin_btn_r  <= '0;
      arm_req_r   <= '0;
      connected_r <= 1'b0;
      silence_r   <= '0;
      speed_x_r   <= '0;
      speed_y_r   <= '0;
      turn_r      <= '0;
    end else if (fire) begin
      mode_auto_r <= mode_auto_nxt;
      lock_r      <= lock_nxt;
      index_r     <= index_nxt;
      prior_btn_r <= prior_btn_nxt;
      lx_r        <= lx_nxt;
      ly_r        <= ly_nxt;
      rx_r        <= rx_nxt;
      ry_r        <= ry_nxt;
      spin_btn_r  <= spin_btn_nxt;
      arm_req_r   <= arm_req_nxt;
      connected_r <= connected_nxt;
      silence_r   <= silence_nxt;
      speed_x_r   <= speed_x_nxt;
      speed_y_r   <= speed_y_nxt;
      turn_r      <= turn_nxt;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/gdcu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdcu_assertions
// Port-level checks for the gamepad drive command unit, bound to the top.
// ----------------------------------------------------------------------------
module gdcu_assertions (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [gdcu_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [gdcu_pkg::KIND_W-1:0]      in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [gdcu_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             cfg_we,
  input logic [gdcu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [gdcu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input only stalls when a result is held back
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with free output");

  // lock can only be raised from auto mode, which is never left
  a_lock_auto: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[66] |-> out_tdata[65])
    else $error("locked outside auto mode");

endmodule

bind gamepad_drive_command_unit gdcu_assertions u_gdcu_assertions (.*);
